// ----- hdl/pdi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdi_pkg: shared types and constants
// Item types, controller states and limits for the integer formatter.
// ----------------------------------------------------------------------------
package pdi_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int MAX_FIELD  = 64;
    localparam int OUT_LIMIT  = 66;
    localparam int DEC_CELLS  = 20;
    localparam int CONV_STEPS = 16;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [2:0] PFX_NONE  = 3'd0;
    localparam logic [2:0] PFX_ZERO  = 3'd1;
    localparam logic [2:0] PFX_LX    = 3'd2;
    localparam logic [2:0] PFX_UX    = 3'd3;
    localparam logic [2:0] PFX_LB    = 3'd4;
    localparam logic [2:0] PFX_UB    = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [63:0] magnitude;
        logic        is_negative;
        logic [1:0]  radix_sel;
        logic        upper_digits;
        logic [6:0]  field_width;
        logic signed [7:0] min_digits;
        logic        left_align;
        logic        pad_zeros;
        logic [2:0]  prefix_kind;
    } request_t;

    typedef struct packed {
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic [1:0] char_count;
        logic       is_last;
    } result_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctl_t;

    typedef logic [DEC_CELLS-1:0][3:0] bcd_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIZE,
        ST_LAYOUT,
        ST_EMIT
    } state_t;

    // ASCII for one digit value
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'd0, d};
        else if (upper)
            c = 8'h41 + {4'd0, d - 4'd10};
        else
            c = 8'h61 + {4'd0, d - 4'd10};
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/padded_integer_to_ascii.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// padded_integer_to_ascii: printf-style integer formatter
// Flow: an accepted item is loaded into the decimal cell row, converted in 16
// steps of four bits each, then sized and laid out; results come from the
// output register.
// A new item is taken only in idle, after its last result is formed (busy is
// high until then); results leave up to two characters a cycle and cannot be stalled.
// Reset: asynchronous, active low; returns to idle and drops any item.
// ----------------------------------------------------------------------------
module padded_integer_to_ascii
    import pdi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          strobe,
    output result_t       result
);

    state_t     state_reg, state_next;
    request_t   req_reg;
    logic [4:0] step_reg, step_next;
    logic [6:0] ndig_reg, ndig_next;
    logic [6:0] zeros_reg, zeros_next;
    logic [7:0] s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [7:0] s0_next, s1_next, s2_next, s3_next, s4_next, s5_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] pos_reg, pos_next;
    logic       strobe_reg, strobe_next;
    result_t    result_reg, result_next;

    chain_ctl_t ctl;
    bcd_row_t   bcd;
    logic       nonzero;
    logic [5:0] msb;

    logic       prec_given;
    logic [6:0] prec;
    logic [6:0] width;
    logic [1:0] npre;
    logic [7:0] body, spaces, lead_sp, zpad_sp, trail_sp, full;
    logic [6:0] nd;
    logic [7:0] c0, c1;

    pdi_digit_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .magnitude (req_reg.magnitude),
        .digits    (bcd),
        .nonzero   (nonzero),
        .msb       (msb)
    );

    // saturated options
    assign prec_given = !req_reg.min_digits[7];
    assign prec  = (req_reg.min_digits[6:0] > 7'(MAX_DIGITS)) ? 7'(MAX_DIGITS)
                                                              : req_reg.min_digits[6:0];
    assign width = (req_reg.field_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD)
                                                         : req_reg.field_width;

    always_comb
    begin
        case (req_reg.prefix_kind)
            PFX_ZERO:                      npre = 2'd1;
            PFX_LX, PFX_UX, PFX_LB, PFX_UB: npre = 2'd2;
            default:                       npre = 2'd0;
        endcase
    end

    // digit value by index from the least significant end
    function automatic logic [3:0] digit_at(input logic [5:0] idx);
        logic [65:0] ext;
        logic [3:0]  d;
        ext = {2'b00, req_reg.magnitude};
        case (req_reg.radix_sel)
            RADIX_BIN: d = {3'd0, ext[idx]};
            RADIX_OCT: d = {1'b0, ext[7'(3) * {1'b0, idx} +: 3]};
            RADIX_DEC: d = (idx < 6'(DEC_CELLS)) ? bcd[5'(idx)] : 4'd0;
            default:   d = ext[{idx[3:0], 2'b00} +: 4];
        endcase
        return d;
    endfunction

    // character at one string position
    function automatic logic [7:0] char_at(input logic [7:0] p);
        logic [7:0] c;
        logic [7:0] k;
        k = s5_reg - 8'd1 - p;
        if (p < s0_reg)
            c = CH_SPACE;
        else if (p < s1_reg)
            c = CH_MINUS;
        else if (p < s2_reg)
        begin
            if (p == s1_reg)
                c = CH_ZERO;
            else
            begin
                case (req_reg.prefix_kind)
                    PFX_LX:  c = 8'h78;
                    PFX_UX:  c = 8'h58;
                    PFX_LB:  c = 8'h62;
                    default: c = 8'h42;
                endcase
            end
        end
        else if (p < s4_reg)
            c = CH_ZERO;
        else if (p < s5_reg)
            c = digit_char(digit_at(k[5:0]), req_reg.upper_digits);
        else
            c = CH_SPACE;
        return c;
    endfunction

    // digit count for the selected radix; decimal from the highest nonzero cell
    always_comb
    begin
        logic [6:0] dn;
        dn = 7'd0;
        for (int k = 0; k < DEC_CELLS; k++)
            if (bcd[k] != 4'd0)
                dn = 7'(k + 1);
        if (!nonzero)
            nd = 7'd1;
        else
        begin
            case (req_reg.radix_sel)
                RADIX_BIN: nd = {1'b0, msb} + 7'd1;
                RADIX_OCT: nd = 7'((13'({msb}) * 13'd43) >> 7) + 7'd1;
                RADIX_DEC: nd = dn;
                default:   nd = {3'd0, msb[5:2]} + 7'd1;
            endcase
        end
        if (prec_given && prec == 7'd0 && !nonzero)
            nd = 7'd0;
    end

    // field layout
    always_comb
    begin
        body     = {7'd0, req_reg.is_negative} + {6'd0, npre}
                 + {1'b0, zeros_reg} + {1'b0, ndig_reg};
        spaces   = ({1'b0, width} > body) ? {1'b0, width} - body : 8'd0;
        lead_sp  = 8'd0;
        zpad_sp  = 8'd0;
        trail_sp = 8'd0;
        if (req_reg.left_align)
            trail_sp = spaces;
        else if (req_reg.pad_zeros && !prec_given)
            zpad_sp = spaces;
        else
            lead_sp = spaces;
        full = body + spaces;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_CONVERT;
            ST_CONVERT: if (step_reg == 5'(CONV_STEPS)) state_next = ST_SIZE;
            ST_SIZE:    state_next = ST_LAYOUT;
            ST_LAYOUT:  state_next = (full == 8'd0) ? ST_IDLE : ST_EMIT;
            ST_EMIT:    if (pos_reg + 8'd2 >= total_reg) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ctl         = '0;
        step_next   = step_reg;
        ndig_next   = ndig_reg;
        zeros_next  = zeros_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        s3_next     = s3_reg;
        s4_next     = s4_reg;
        s5_next     = s5_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        c0          = char_at(pos_reg);
        c1          = char_at(pos_reg + 8'd1);
        case (state_reg)
            ST_IDLE:
            begin
                step_next = 5'd0;
            end
            ST_CONVERT:
            begin
                if (step_reg == 5'd0)
                    ctl.load = 1'b1;
                else
                    ctl.shift = 1'b1;
                step_next = step_reg + 5'd1;
            end
            ST_SIZE:
            begin
                ndig_next  = nd;
                zeros_next = (prec_given && prec > nd) ? prec - nd : 7'd0;
            end
            ST_LAYOUT:
            begin
                s0_next    = lead_sp;
                s1_next    = lead_sp + {7'd0, req_reg.is_negative};
                s2_next    = s1_next + {6'd0, npre};
                s3_next    = s2_next + zpad_sp;
                s4_next    = s3_next + {1'b0, zeros_reg};
                s5_next    = s4_next + {1'b0, ndig_reg};
                total_next = (full > 8'(OUT_LIMIT)) ? 8'(OUT_LIMIT) : full;
                pos_next   = 8'd0;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                result_next.char_first = c0;
                if (pos_reg + 8'd1 < total_reg)
                begin
                    result_next.char_second = c1;
                    result_next.char_count  = 2'd2;
                end
                else
                begin
                    result_next.char_second = 8'd0;
                    result_next.char_count  = 2'd1;
                end
                result_next.is_last = (pos_reg + 8'd2 >= total_reg);
                pos_next = pos_reg + 8'd2;
            end
            default:
            begin
                step_next = 5'd0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            step_reg   <= 5'd0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            step_reg   <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            req_reg <= request;
        ndig_reg   <= ndig_next;
        zeros_reg  <= zeros_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        s3_reg     <= s3_next;
        s4_reg     <= s4_next;
        s5_reg     <= s5_next;
        total_reg  <= total_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ----- hdl/pdi_bcd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdi_bcd_cell: one decimal digit of the conversion row
// Takes four bits per cycle from its lower neighbor while shift is set, adjusting before each
// shift, and hands its four outgoing bits to the upper neighbor.
// ----------------------------------------------------------------------------
module pdi_bcd_cell
    import pdi_pkg::*;
(
    input  wire logic       clk,
    input  wire chain_ctl_t ctl,
    input  wire logic [3:0] bits_in,
    output logic [3:0]      bits_out,
    output logic [3:0]      digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;

    // four add-3 and shift steps, first incoming bit is bits_in[3]
    always_comb
    begin
        logic [3:0] d;
        logic [3:0] adj;
        d = digit_reg;
        bits_out = '0;
        for (int j = 0; j < 4; j++)
        begin
            adj = (d >= 4'd5) ? d + 4'd3 : d;
            bits_out[3-j] = adj[3];
            d = {adj[2:0], bits_in[3-j]};
        end
        digit_next = d;
    end

    // clear on load, advance on shift
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            digit_reg <= '0;
        else if (ctl.shift)
            digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule
`default_nettype wire

// ----- hdl/pdi_digit_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdi_digit_chain: binary to decimal conversion row
// Shifts the magnitude into a row of decimal cells four bits a cycle while
// shift is set, and finds the most significant set bit on the way.
// ----------------------------------------------------------------------------
module pdi_digit_chain
    import pdi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire chain_ctl_t  ctl,
    input  wire logic [63:0] magnitude,
    output bcd_row_t         digits,
    output logic             nonzero,
    output logic [5:0]       msb
);

    logic [63:0] shift_reg;
    logic [5:0]  base_reg;
    logic        found_reg;
    logic [5:0]  msb_reg;
    logic [3:0]  nib;
    logic [1:0]  lead;
    logic [DEC_CELLS:0][3:0] link;

    assign nib  = shift_reg[63:60];
    assign lead = nib[3] ? 2'd0 : (nib[2] ? 2'd1 : (nib[1] ? 2'd2 : 2'd3));
    assign link[0] = nib;

    // row of decimal cells
    for (genvar i = 0; i < DEC_CELLS; i++)
    begin : g_cell
        pdi_bcd_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .bits_in  (link[i]),
            .bits_out (link[i+1]),
            .digit    (digits[i])
        );
    end

    // hold magnitude and track the top set bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            base_reg  <= '1;
        end
        else if (ctl.load)
        begin
            found_reg <= 1'b0;
            base_reg  <= '1;
        end
        else if (ctl.shift)
        begin
            base_reg <= base_reg - 6'd4;
            if (!found_reg && nib != 4'd0)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            shift_reg <= magnitude;
            msb_reg   <= '0;
        end
        else if (ctl.shift)
        begin
            shift_reg <= {shift_reg[59:0], 4'd0};
            if (!found_reg && nib != 4'd0)
                msb_reg <= base_reg - {4'd0, lead};
        end
    end

    assign nonzero = found_reg;
    assign msb     = msb_reg;

endmodule
`default_nettype wire
